@@ rtl/bia_pkg.sv @@
`timescale 1ns / 1ps

package bia_pkg;

  // Fixed field widths of the request and result beats.
  localparam int ID_W     = 10;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // Slot positions run up to 1024 inclusive, so they need one bit more than an id.
  localparam int POS_W = ID_W + 1;

  // The free bitmap is stored as words of this many slots.
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int WIDX_W    = POS_W - BIT_W;
  localparam int ID_SPAN   = 1 << ID_W;

  localparam int DEF_ID_SLOTS = 1024;
  localparam logic [ID_W-1:0] HIGHEST_ID_RST = ID_W'(ID_SPAN - 1);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RESERVE = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_REJECT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MODIFY,
    ST_DONE
  } ctl_state_t;

  // Index of the lowest set bit of a bitmap word (zero when the word is empty).
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ rtl/bitmap_id_allocator.sv @@
`timescale 1ns / 1ps

// Identifier allocator over a free bitmap. Slots 0 through the configured highest
// id exist, and a set bit in the bitmap marks a slot as free. Each input beat
// carries an operation in in_tuser and an id in in_tdata. Allocate hands out the
// lowest free slot at or after a rotating cursor; if there is none it searches
// again from slot 1, and it reports full (status 1, id 0) when that fails too.
// Slot 0 is never handed out by allocate and can only be taken by a reserve.
// Reserve claims the given id if it is in range and free and otherwise rejects it
// (status 2). Release frees an in-range id and ignores any other. Every request
// gives exactly one result beat, and the id of a reserve or release is echoed.
// The bitmap sits in a single-port memory of 32-slot words that is read and
// written by one word-wide find-first unit under a small sequencer, so the block
// takes one request at a time. Allocate scans the bitmap word by word, making
// at most two sweeps over the words in range, and stops at the first free slot
// that it finds. After reset the block runs a clearing pass that writes every
// memory word to all-free, one word a cycle; requests wait until it ends, but
// the highest_id register takes writes at any time. Write highest_id only while
// no request is in flight. The result is held in an output register, so the
// next request is accepted while a finished result still waits on out_tready.

module bitmap_id_allocator
  import bia_pkg::*;
#(
  parameter int ID_SLOTS = DEF_ID_SLOTS
) (
  input  logic             clk,
  input  logic             rst_n,

  // Request channel.
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,   // [9:0] request_id, [15:10] zero
  input  logic [OP_W-1:0]  in_tuser,   // [1:0] operation

  // Result channel.
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,  // [9:0] granted_id, [15:10] zero
  output logic [STATUS_W-1:0] out_tuser, // [1:0] status

  // Configuration write channel for highest_id.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [ID_W-1:0]  cfg_data
);

  localparam int WORDS   = (ID_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  // Usable slots are also capped by the id width.
  localparam logic [POS_W-1:0] SLOTS_POS =
    POS_W'((ID_SLOTS < ID_SPAN) ? ID_SLOTS : ID_SPAN);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

  // Bitmap memory: one bit per slot, set means free.
  logic [WORD_W-1:0]  mem [WORDS];
  logic [WORD_W-1:0]  rd_data_r;
  logic               rd_en;
  logic [WADDR_W-1:0] rd_addr;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;

  ctl_state_t         state_r, state_nxt;
  logic [ID_W-1:0]    hid_r;
  logic [POS_W-1:0]   cursor_r, cursor_nxt;
  logic [WADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // Scan context of the allocate in progress.
  logic [WIDX_W-1:0]  scan_w_r, scan_w_nxt;
  logic [BIT_W-1:0]   start_lo_r, start_lo_nxt;
  logic               first_r, first_nxt;
  logic               phase2_r, phase2_nxt;

  // Request and result held while the request is worked on.
  op_t                op_r, op_nxt;
  logic [ID_W-1:0]    rid_r, rid_nxt;
  logic [ID_W-1:0]    res_id_r, res_id_nxt;
  status_t            res_sts_r, res_sts_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  status_t            out_sts_r, out_sts_nxt;

  // Derived limits.
  logic [POS_W-1:0]   hid_p1;
  logic [POS_W-1:0]   lim;
  logic [POS_W-1:0]   lim_m1;
  logic [WIDX_W-1:0]  last_w;
  logic [WORD_W-1:0]  lo_mask;
  logic [WORD_W-1:0]  hi_mask;
  logic [WORD_W-1:0]  cand;
  logic [BIT_W-1:0]   hit_bit;
  logic [POS_W-1:0]   hit_pos;
  logic [POS_W-1:0]   alloc_start;
  logic               in_acc;
  op_t                in_op;
  logic [ID_W-1:0]    in_rid;

  assign hid_p1 = {1'b0, hid_r} + POS_ONE;
  assign lim    = (hid_p1 > SLOTS_POS) ? SLOTS_POS : hid_p1;
  assign lim_m1 = lim - POS_ONE;
  assign last_w = lim_m1[POS_W-1:BIT_W];

  // The find-first unit masks off slots before the search start in the first
  // word and slots at or beyond the limit in the last word.
  assign lo_mask = first_r ? ({WORD_W{1'b1}} << start_lo_r) : {WORD_W{1'b1}};
  assign hi_mask = (scan_w_r == last_w) ?
                   ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - lim_m1[BIT_W-1:0])) :
                   {WORD_W{1'b1}};
  assign cand    = rd_data_r & lo_mask & hi_mask;
  assign hit_bit = lowest_set(cand);
  assign hit_pos = {scan_w_r, hit_bit};

  assign alloc_start = (cursor_r < lim) ? cursor_r : POS_ONE;

  assign in_op     = op_t'(in_tuser);
  assign in_rid    = in_tdata[ID_W-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - ID_W){1'b0}}, out_id_r};
  assign out_tuser  = out_sts_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      hid_r       <= HIGHEST_ID_RST;
      cursor_r    <= POS_ONE;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        hid_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_w_r   <= scan_w_nxt;
    start_lo_r <= start_lo_nxt;
    first_r    <= first_nxt;
    phase2_r   <= phase2_nxt;
    op_r       <= op_nxt;
    rid_r      <= rid_nxt;
    res_id_r   <= res_id_nxt;
    res_sts_r  <= res_sts_nxt;
    out_id_r   <= out_id_nxt;
    out_sts_r  <= out_sts_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    clr_addr_nxt  = clr_addr_r;
    scan_w_nxt    = scan_w_r;
    start_lo_nxt  = start_lo_r;
    first_nxt     = first_r;
    phase2_nxt    = phase2_r;
    op_nxt        = op_r;
    rid_nxt       = rid_r;
    res_id_nxt    = res_id_r;
    res_sts_nxt   = res_sts_r;
    out_id_nxt    = out_id_r;
    out_sts_nxt   = out_sts_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;

    case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = {WORD_W{1'b1}};
        clr_addr_nxt = clr_addr_r + WADDR_W'(1);
        if (clr_addr_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_op;
          rid_nxt     = in_rid;
          res_id_nxt  = in_rid;
          res_sts_nxt = STS_OK;
          case (in_op)
            OP_ALLOC: begin
              // A cursor at or past the limit starts straight at the second sweep.
              phase2_nxt = !(cursor_r < lim);
              if (alloc_start < lim) begin
                rd_en        = 1'b1;
                rd_addr      = WADDR_W'(alloc_start[POS_W-1:BIT_W]);
                scan_w_nxt   = alloc_start[POS_W-1:BIT_W];
                start_lo_nxt = alloc_start[BIT_W-1:0];
                first_nxt    = 1'b1;
                state_nxt    = ST_SCAN;
              end else begin
                cursor_nxt  = POS_ONE;
                res_id_nxt  = '0;
                res_sts_nxt = STS_FULL;
                state_nxt   = ST_DONE;
              end
            end
            OP_RESERVE, OP_RELEASE: begin
              if ({1'b0, in_rid} < lim) begin
                rd_en     = 1'b1;
                rd_addr   = WADDR_W'(in_rid[ID_W-1:BIT_W]);
                state_nxt = ST_MODIFY;
              end else begin
                // Out-of-range reserve is rejected; out-of-range release is ignored.
                if (in_op == OP_RESERVE) begin
                  res_sts_nxt = STS_REJECT;
                end
                state_nxt = ST_DONE;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (cand != '0) begin
          // Claim the slot in the same cycle it is found.
          wr_en       = 1'b1;
          wr_addr     = WADDR_W'(scan_w_r);
          wr_data     = rd_data_r & ~(WORD_W'(1) << hit_bit);
          cursor_nxt  = hit_pos + POS_ONE;
          res_id_nxt  = hit_pos[ID_W-1:0];
          res_sts_nxt = STS_OK;
          state_nxt   = ST_DONE;
        end else if (scan_w_r == last_w) begin
          if (phase2_r || !(POS_ONE < lim)) begin
            cursor_nxt  = POS_ONE;
            res_id_nxt  = '0;
            res_sts_nxt = STS_FULL;
            state_nxt   = ST_DONE;
          end else begin
            // Nothing from the cursor on: wrap and search again from slot 1.
            rd_en        = 1'b1;
            rd_addr      = '0;
            scan_w_nxt   = '0;
            start_lo_nxt = POS_ONE[BIT_W-1:0];
            first_nxt    = 1'b1;
            phase2_nxt   = 1'b1;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = WADDR_W'(scan_w_r + WIDX_W'(1));
          scan_w_nxt = scan_w_r + WIDX_W'(1);
          first_nxt  = 1'b0;
        end
      end

      ST_MODIFY: begin
        wr_addr = WADDR_W'(rid_r[ID_W-1:BIT_W]);
        if (op_r == OP_RESERVE) begin
          if (rd_data_r[rid_r[BIT_W-1:0]]) begin
            wr_en   = 1'b1;
            wr_data = rd_data_r & ~(WORD_W'(1) << rid_r[BIT_W-1:0]);
          end else begin
            res_sts_nxt = STS_REJECT;
          end
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data_r | (WORD_W'(1) << rid_r[BIT_W-1:0]);
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_sts_nxt   = res_sts_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // A full report always carries id zero.
  a_full_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == STS_FULL)) |-> (out_tdata == '0))
    else $error("full result with nonzero id");

  // The cursor always points into the slot range plus one.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_r != '0) && (cursor_r <= POS_W'(ID_SPAN)))
    else $error("search cursor out of range");

  // Once the clearing pass is over it never runs again without a reset.
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |=> (state_r != ST_CLEAR))
    else $error("clearing pass restarted");

  // A request is never accepted while the bitmap memory is being written.
  a_no_accept_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !in_acc)
    else $error("request accepted during a bitmap write");
`endif

endmodule

@@ tb/bitmap_id_allocator_tb.sv @@
`timescale 1ns / 1ps

import bia_pkg::*;

// One expected result beat: the id that comes back and its status.
typedef struct packed {
  logic [ID_W-1:0] id;
  status_t         status;
} grant_t;

// Scoreboard: keeps its own copy of the free bitmap, the search cursor and the
// highest_id setting, predicts the result of every accepted request and checks
// the result beats against those predictions in order.
class id_alloc_scoreboard;
  bit              slot_free [DEF_ID_SLOTS];
  int unsigned     cursor;
  logic [ID_W-1:0] highest_id;
  grant_t          pending_grants [$];
  int              mismatches;

  function new();
    foreach (slot_free[i]) slot_free[i] = 1'b1;
    cursor     = 1;
    highest_id = HIGHEST_ID_RST;
    mismatches = 0;
  endfunction

  function void set_highest_id(input logic [ID_W-1:0] value);
    highest_id = value;
  endfunction

  // Lowest free slot in [from, lim), or lim when there is none.
  function int unsigned first_free(input int unsigned from, input int unsigned lim);
    for (int unsigned i = from; i < lim; i++) begin
      if (slot_free[i]) return i;
    end
    return lim;
  endfunction

  function void flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endfunction

  // Called once per accepted request beat; updates the bitmap and queues the
  // result that the block has to return for it.
  function void note_request(input op_t op, input logic [ID_W-1:0] rid);
    grant_t      g;
    int unsigned lim;
    int unsigned pos;
    lim = int'(highest_id) + 1;
    if (lim > DEF_ID_SLOTS) lim = DEF_ID_SLOTS;
    g.id     = rid;
    g.status = STS_OK;
    case (op)
      OP_ALLOC: begin
        // A cursor at or past the limit skips straight to the retry from 1.
        pos = lim;
        if (cursor < lim) pos = first_free(cursor, lim);
        if (pos >= lim) begin
          cursor = 1;
          pos    = first_free(1, lim);
        end
        if (pos < lim) begin
          slot_free[pos] = 1'b0;
          cursor         = pos + 1;
          g.id           = ID_W'(pos);
        end else begin
          g.id     = '0;
          g.status = STS_FULL;
        end
      end
      OP_RESERVE: begin
        if (int'(rid) < lim && slot_free[rid]) slot_free[rid] = 1'b0;
        else g.status = STS_REJECT;
      end
      OP_RELEASE: begin
        // Out-of-range releases are silently dropped.
        if (int'(rid) < lim) slot_free[rid] = 1'b1;
      end
      default: ;
    endcase
    pending_grants.push_back(g);
  endfunction

  function void check_result(input logic [15:0] data, input logic [STATUS_W-1:0] status);
    grant_t want;
    if (pending_grants.size() == 0) begin
      flag($sformatf("unexpected result beat: id %0d status %0d", data, status));
      return;
    end
    want = pending_grants.pop_front();
    if (data !== {6'd0, want.id} || status !== want.status) begin
      flag($sformatf("mismatch: expected id %0d status %0d, got id %0d status %0d",
                     want.id, want.status, data, status));
    end
  endfunction
endclass

module bitmap_id_allocator_tb;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [15:0]         in_tdata;   // [9:0] request_id, [15:10] zero
  logic [OP_W-1:0]     in_tuser;   // [1:0] operation
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;  // [9:0] granted_id, [15:10] zero
  logic [STATUS_W-1:0] out_tuser;  // [1:0] status
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ID_W-1:0]     cfg_data;

  id_alloc_scoreboard sb = new();

  // When set, the matching side runs back to back with no idle cycles. Each
  // side flips its flag now and then, so stretches without gaps alternate with
  // stretches of random gaps.
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  bitmap_id_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Sends one request beat after a random number of idle cycles. The prediction
  // is made at the edge where the beat is accepted, so the scoreboard sees the
  // requests in the same order as the block.
  task automatic send_request(input op_t op, input logic [ID_W-1:0] rid);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, rid};
    in_tuser  <= op;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_request(op, rid);
  endtask

  // Stops sending and waits until every predicted result has come back. A few
  // spare cycles follow so the block is certainly idle before a register write.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_highest_id(input logic [ID_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_highest_id(value);
  endtask

  // One random phase at a fixed highest_id. Most ids fall inside the usable
  // range, the rest anywhere in the 10-bit field so out-of-range reserves and
  // releases show up as well. alloc_pct tunes how fast the bitmap fills up.
  task automatic run_phase(input logic [ID_W-1:0] hid, input int items, input int alloc_pct);
    op_t             op;
    logic [ID_W-1:0] rid;
    int              roll;
    int              top;
    write_highest_id(hid);
    top = (hid == '1) ? 1023 : int'(hid) + 1;
    for (int n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) op = OP_ALLOC;
      else if (roll < alloc_pct + 20) op = OP_RESERVE;
      else if (roll < 95) op = OP_RELEASE;
      else op = OP_NONE;
      if ($urandom_range(0, 9) < 7) rid = ID_W'($urandom_range(0, top));
      else rid = ID_W'($urandom_range(0, 1023));
      send_request(op, rid);
    end
    drain();
  endtask

  // Result side: draws a stall per beat, then holds tready high until a beat
  // is taken. tready is only lowered when the next stall is nonzero, so it is
  // never dropped and raised again in the same step.
  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_result(out_tdata, out_tuser);
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_ALLOC;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Full range. The first allocations skip slot zero, which only a reserve
    // can take. Reserve and release at both ends of the id field, a double
    // reserve, a release of an id that is already free and the unused opcode.
    write_highest_id(10'd1023);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, 10'd1023);
    send_request(OP_RESERVE, 10'd0);
    send_request(OP_RESERVE, 10'd0);
    send_request(OP_RELEASE, 10'd0);
    send_request(OP_RESERVE, 10'd1023);
    send_request(OP_RESERVE, 10'd1023);
    send_request(OP_RELEASE, 10'd1023);
    send_request(OP_RELEASE, 10'd700);
    send_request(OP_NONE, 10'd1023);
    send_request(OP_NONE, 10'd0);
    drain();

    // Lowest setting with an allocatable slot: the cursor now sits past the limit, slot 1 is
    // taken, so the first allocate reports full. Out-of-range reserve and
    // release follow.
    write_highest_id(10'd1);
    send_request(OP_ALLOC, '0);
    send_request(OP_RELEASE, 10'd1);
    send_request(OP_ALLOC, '0);
    send_request(OP_RESERVE, 10'd2);
    send_request(OP_RELEASE, 10'd2);
    drain();

    // highest_id of zero leaves only slot zero, so allocate is always full.
    write_highest_id(10'd0);
    send_request(OP_ALLOC, '0);
    send_request(OP_RESERVE, 10'd0);
    send_request(OP_RELEASE, 10'd0);
    drain();

    // A tiny range that fills up and then wraps after a release.
    write_highest_id(10'd3);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_RELEASE, 10'd2);
    send_request(OP_ALLOC, '0);
    drain();

    // Random phases at the extremes and in between. The small ranges reach
    // full and wrap-around often; the first full-range phase sees mostly allocations.
    run_phase(10'd1, 100, 45);
    run_phase(10'd1023, 100, 60);
    run_phase(ID_W'($urandom_range(2, 15)), 100, 45);
    run_phase(ID_W'($urandom_range(16, 80)), 100, 50);
    run_phase(ID_W'($urandom_range(81, 1022)), 100, 45);
    run_phase(10'd31, 100, 55);
    run_phase(10'd1023, 100, 35);

    // Extra time for any stray result beat after the last expected one.
    repeat (80) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_grants.size() == 0) begin
      $display("bitmap_id_allocator test passed");
    end else begin
      $display("bitmap_id_allocator test failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("bitmap_id_allocator test failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bia_pkg.sv
rtl/bitmap_id_allocator.sv
tb/bitmap_id_allocator_tb.sv
